@@ rtl/stop_and_wait_arq_csma_mac_defines.svh @@
// Assertion macros shared by the link controller RTL.
`ifndef STOP_AND_WAIT_ARQ_CSMA_MAC_DEFINES_SVH
`define STOP_AND_WAIT_ARQ_CSMA_MAC_DEFINES_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define SMAC_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("smac check failed");

// Checks that the consequent holds in the cycle after the antecedent.
`define SMAC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("smac check failed");

`endif

@@ rtl/smac_pkg.sv @@
// Shared types and constants of the link controller.
package smac_pkg;

    // Event classes produced by the front end.
    typedef enum logic [2:0] {
        EV_TICK,
        EV_HOST,
        EV_RX_MSG,
        EV_RX_ACK,
        EV_RX_OTHER,
        EV_SCAN_FREE,
        EV_SCAN_BUSY,
        EV_SCAN_ERR
    } ev_t;

    typedef struct packed {
        ev_t        ev;
        logic [6:0] len;
    } item_t;

    typedef enum logic [2:0] {
        ACT_NONE,
        ACT_START_RX,
        ACT_REQ_SCAN,
        ACT_SEND_MSG,
        ACT_SEND_ACK,
        ACT_DELIVER,
        ACT_GAVE_UP
    } act_t;

    typedef enum logic [1:0] {
        STG_IDLE,
        STG_SEND_MSG,
        STG_SEND_ACK
    } stage_t;

    typedef enum logic {
        BK_RUN,
        BK_DIV
    } bstate_t;

    // Raw input codes.
    localparam logic [1:0] REQ_TICK = 2'd0;
    localparam logic [1:0] REQ_HOST = 2'd1;
    localparam logic [1:0] REQ_RX   = 2'd2;
    localparam logic [1:0] RX_MSG   = 2'd0;
    localparam logic [1:0] RX_ACK   = 2'd1;
    localparam logic [1:0] SCAN_FREE = 2'd0;
    localparam logic [1:0] SCAN_BUSY = 2'd1;

    // Configuration register indexes.
    localparam logic [2:0] CFG_ACK_TIMEOUT = 3'd0;
    localparam logic [2:0] CFG_RETRY_LIMIT = 3'd1;
    localparam logic [2:0] CFG_BACKOFF_MIN = 3'd2;
    localparam logic [2:0] CFG_BACKOFF_MAX = 3'd3;
    localparam logic [2:0] CFG_RNG_SEED    = 3'd4;

    // Register reset values.
    localparam logic [15:0] ACK_TIMEOUT_RST = 16'd50;
    localparam logic [3:0]  RETRY_LIMIT_RST = 4'd2;
    localparam logic [7:0]  BACKOFF_MIN_RST = 8'd2;
    localparam logic [7:0]  BACKOFF_MAX_RST = 8'd10;
    localparam logic [31:0] RNG_SEED_RST    = 32'd1;

    localparam logic [31:0] LFSR_TAPS = 32'h8020_0003;

    // Serial remainder unit: quotient bits retired per cycle.
    localparam int DIV_STEPS  = 4;
    localparam int DIV_CYCLES = 32 / DIV_STEPS;

    localparam int QUEUE_DEPTH = 2;

endpackage

@@ rtl/smac_fifo.sv @@
// Small first-in first-out queue of event items.
module smac_fifo #(
    parameter int WIDTH = 10,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [WIDTH-1:0] wr_data,
    output logic             full,
    input  logic             rd_en,
    output logic [WIDTH-1:0] rd_data,
    output logic             empty
);
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_wr, do_rd;

    assign full    = (count_reg == CNT_FULL);
    assign empty   = (count_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

@@ rtl/smac_front.sv @@
// Front end: classifies raw events and queues them for the back end.
module smac_front #(
    parameter int MAX_PAYLOAD = 64
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    output logic           full,
    input  logic [1:0]     req_type,
    input  logic [1:0]     rx_kind,
    input  logic [1:0]     scan_status,
    input  logic [6:0]     host_length,
    input  logic           q_pop,
    output smac_pkg::item_t q_item,
    output logic           q_empty
);
    import smac_pkg::*;

    localparam logic [7:0] MAX_LEN = 8'(MAX_PAYLOAD);

    item_t cls_item;

    always_comb
    begin
        cls_item.len = host_length;
        if ({1'b0, host_length} > MAX_LEN)
        begin
            cls_item.len = MAX_LEN[6:0];
        end
        unique case (req_type)
            REQ_TICK: cls_item.ev = EV_TICK;
            REQ_HOST: cls_item.ev = EV_HOST;
            REQ_RX:
            begin
                if (rx_kind == RX_MSG)
                begin
                    cls_item.ev = EV_RX_MSG;
                end
                else if (rx_kind == RX_ACK)
                begin
                    cls_item.ev = EV_RX_ACK;
                end
                else
                begin
                    cls_item.ev = EV_RX_OTHER;
                end
            end
            default:
            begin
                if (scan_status == SCAN_FREE)
                begin
                    cls_item.ev = EV_SCAN_FREE;
                end
                else if (scan_status == SCAN_BUSY)
                begin
                    cls_item.ev = EV_SCAN_BUSY;
                end
                else
                begin
                    cls_item.ev = EV_SCAN_ERR;
                end
            end
        endcase
    end

    smac_fifo #(
        .WIDTH ($bits(item_t)),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (push),
        .wr_data (cls_item),
        .full    (full),
        .rd_en   (q_pop),
        .rd_data (q_item),
        .empty   (q_empty)
    );

endmodule

@@ rtl/smac_back.sv @@
// Back end: protocol state, timers, backoff draw and the result register.
`include "stop_and_wait_arq_csma_mac_defines.svh"
module smac_back #(
    parameter int TIMER_BITS = 16
) (
    input  logic            clk,
    input  logic            rst_n,
    input  smac_pkg::item_t q_item,
    input  logic            q_empty,
    output logic            q_pop,
    input  logic            cfg_valid,
    output logic            cfg_ready,
    input  logic [2:0]      cfg_index,
    input  logic [31:0]     cfg_data,
    output logic            empty,
    input  logic            pop,
    output logic [2:0]      action,
    output logic [6:0]      message_length,
    output logic [3:0]      retry_count,
    output logic            awaiting_ack
);
    import smac_pkg::*;

    localparam logic [TIMER_BITS-1:0] TIMER_MAX = '1;
    localparam int CMP_W = (TIMER_BITS > 16) ? TIMER_BITS : 16;
    localparam int DCNT_W = $clog2(DIV_CYCLES);
    localparam logic [DCNT_W-1:0] DCNT_LAST = DCNT_W'(DIV_CYCLES - 1);

    // Configuration.
    logic [15:0] ack_to_reg;
    logic [3:0]  retry_lim_reg;
    logic [7:0]  bo_min_reg, bo_max_reg;

    // Protocol state.
    stage_t                stage_reg, stage_next;
    logic                  waiting_reg, waiting_next;
    logic                  listening_reg, listening_next;
    logic [3:0]            retries_reg, retries_next;
    logic [TIMER_BITS-1:0] ack_el_reg, ack_el_next;
    logic [TIMER_BITS-1:0] csma_el_reg, csma_el_next;
    logic [7:0]            backoff_reg, backoff_next;
    logic                  scan_pend_reg, scan_pend_next;
    logic [6:0]            held_reg, held_next;
    logic [31:0]           lfsr_reg, lfsr_next;

    // Sequencer and remainder unit.
    bstate_t           bstate_reg, bstate_next;
    logic [DCNT_W-1:0] div_cnt_reg;
    logic [31:0]       div_num_reg, div_num_next;
    logic [7:0]        div_rem_reg, div_rem_next;

    // Result register.
    logic       res_valid_reg;
    act_t       act_reg;
    logic [6:0] mlen_reg;
    logic [3:0] retry_reg;
    logic       await_reg;

    logic                  go, div_done, start_div, cfg_we;
    act_t                  act;
    logic [6:0]            mlen;
    logic [TIMER_BITS-1:0] ack_tick, csma_tick;
    logic                  expired, scan_ok_tick, scan_ok_now;
    logic [31:0]           lfsr_step;
    logic [7:0]            lo, hi;
    logic [8:0]            span;

    assign cfg_ready = 1'b1;
    assign cfg_we    = cfg_valid;

    assign ack_tick  = (ack_el_reg == TIMER_MAX) ? ack_el_reg : ack_el_reg + 1'b1;
    assign csma_tick = (csma_el_reg == TIMER_MAX) ? csma_el_reg : csma_el_reg + 1'b1;
    assign expired   = waiting_reg &&
                       ((CMP_W'(ack_tick) > CMP_W'(ack_to_reg)) || (ack_tick == TIMER_MAX));
    assign scan_ok_tick = !scan_pend_reg && (csma_tick >= TIMER_BITS'(backoff_reg));
    assign scan_ok_now  = !scan_pend_reg && (csma_el_reg >= TIMER_BITS'(backoff_reg));

    assign lfsr_step = lfsr_reg[0] ? ((lfsr_reg >> 1) ^ LFSR_TAPS) : (lfsr_reg >> 1);

    assign lo   = (bo_min_reg > bo_max_reg) ? bo_max_reg : bo_min_reg;
    assign hi   = (bo_min_reg > bo_max_reg) ? bo_min_reg : bo_max_reg;
    assign span = {1'b0, hi} - {1'b0, lo} + 9'd1;

    // Sequencer next state.
    always_comb
    begin
        bstate_next = bstate_reg;
        unique case (bstate_reg)
            BK_RUN:
            begin
                if (go && start_div)
                begin
                    bstate_next = BK_DIV;
                end
            end
            BK_DIV:
            begin
                if (div_done)
                begin
                    bstate_next = BK_RUN;
                end
            end
            default: bstate_next = BK_RUN;
        endcase
    end

    // Sequencer outputs.
    always_comb
    begin
        go       = 1'b0;
        div_done = 1'b0;
        unique case (bstate_reg)
            BK_RUN:  go = !q_empty && (!res_valid_reg || pop);
            BK_DIV:  div_done = (div_cnt_reg == DCNT_LAST);
            default: go = 1'b0;
        endcase
    end

    assign q_pop = go;

    // Event execution.
    always_comb
    begin
        stage_next     = stage_reg;
        waiting_next   = waiting_reg;
        listening_next = listening_reg;
        retries_next   = retries_reg;
        ack_el_next    = ack_el_reg;
        csma_el_next   = csma_el_reg;
        scan_pend_next = scan_pend_reg;
        held_next      = held_reg;
        act            = ACT_NONE;
        mlen           = '0;
        start_div      = 1'b0;
        unique case (q_item.ev)
            EV_TICK:
            begin
                ack_el_next  = ack_tick;
                csma_el_next = csma_tick;
                if (stage_reg == STG_IDLE)
                begin
                    if (expired)
                    begin
                        if (retries_reg < retry_lim_reg)
                        begin
                            retries_next = retries_reg + 1'b1;
                            stage_next   = STG_SEND_MSG;
                            if (scan_ok_tick)
                            begin
                                scan_pend_next = 1'b1;
                                act            = ACT_REQ_SCAN;
                            end
                        end
                        else
                        begin
                            waiting_next = 1'b0;
                            retries_next = '0;
                            act          = ACT_GAVE_UP;
                        end
                    end
                    else if (!listening_reg)
                    begin
                        listening_next = 1'b1;
                        act            = ACT_START_RX;
                    end
                end
                else if (scan_ok_tick)
                begin
                    scan_pend_next = 1'b1;
                    act            = ACT_REQ_SCAN;
                end
            end
            EV_HOST:
            begin
                if (stage_reg == STG_IDLE && !waiting_reg)
                begin
                    held_next = q_item.len;
                    if (q_item.len != '0)
                    begin
                        stage_next = STG_SEND_MSG;
                        if (scan_ok_now)
                        begin
                            scan_pend_next = 1'b1;
                            act            = ACT_REQ_SCAN;
                        end
                    end
                    else if (!listening_reg)
                    begin
                        listening_next = 1'b1;
                        act            = ACT_START_RX;
                    end
                end
            end
            EV_RX_MSG:
            begin
                if (stage_reg == STG_IDLE)
                begin
                    stage_next = STG_SEND_ACK;
                    act        = ACT_DELIVER;
                end
            end
            EV_RX_ACK:
            begin
                if (stage_reg == STG_IDLE)
                begin
                    waiting_next = 1'b0;
                    retries_next = '0;
                    ack_el_next  = '0;
                end
            end
            EV_RX_OTHER: act = ACT_NONE;
            EV_SCAN_FREE:
            begin
                if (scan_pend_reg && stage_reg != STG_IDLE)
                begin
                    scan_pend_next = 1'b0;
                    csma_el_next   = '0;
                    listening_next = 1'b0;
                    stage_next     = STG_IDLE;
                    if (stage_reg == STG_SEND_MSG)
                    begin
                        act          = ACT_SEND_MSG;
                        mlen         = held_reg;
                        waiting_next = 1'b1;
                        ack_el_next  = '0;
                    end
                    else
                    begin
                        act = ACT_SEND_ACK;
                    end
                end
            end
            EV_SCAN_BUSY:
            begin
                if (scan_pend_reg && stage_reg != STG_IDLE)
                begin
                    scan_pend_next = 1'b0;
                    csma_el_next   = '0;
                    start_div      = 1'b1;
                end
            end
            EV_SCAN_ERR:
            begin
                if (scan_pend_reg && stage_reg != STG_IDLE)
                begin
                    scan_pend_next = 1'b0;
                end
            end
            default: act = ACT_NONE;
        endcase
    end

    // Random generator; a seed write reloads it.
    always_comb
    begin
        lfsr_next = lfsr_reg;
        if (cfg_we && cfg_index == CFG_RNG_SEED)
        begin
            lfsr_next = (cfg_data == '0) ? 32'd1 : cfg_data;
        end
        else if (go && start_div)
        begin
            lfsr_next = (lfsr_step == '0) ? 32'd1 : lfsr_step;
        end
    end

    // Restoring remainder, a few dividend bits per cycle, MSB first.
    always_comb
    begin
        logic [31:0] num;
        logic [7:0]  rem;
        logic [8:0]  trial;
        num = div_num_reg;
        rem = div_rem_reg;
        for (int i = 0; i < DIV_STEPS; i++)
        begin
            trial = {rem, num[31]};
            num   = num << 1;
            if (trial >= span)
            begin
                trial = trial - span;
            end
            rem = trial[7:0];
        end
        div_num_next = num;
        div_rem_next = rem;
    end

    assign backoff_next = lo + div_rem_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ack_to_reg    <= ACK_TIMEOUT_RST;
            retry_lim_reg <= RETRY_LIMIT_RST;
            bo_min_reg    <= BACKOFF_MIN_RST;
            bo_max_reg    <= BACKOFF_MAX_RST;
            stage_reg     <= STG_IDLE;
            waiting_reg   <= 1'b0;
            listening_reg <= 1'b0;
            retries_reg   <= '0;
            ack_el_reg    <= '0;
            csma_el_reg   <= '0;
            backoff_reg   <= '0;
            scan_pend_reg <= 1'b0;
            held_reg      <= '0;
            lfsr_reg      <= RNG_SEED_RST;
            bstate_reg    <= BK_RUN;
            div_cnt_reg   <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            bstate_reg <= bstate_next;
            lfsr_reg   <= lfsr_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_ACK_TIMEOUT: ack_to_reg    <= cfg_data[15:0];
                    CFG_RETRY_LIMIT: retry_lim_reg <= cfg_data[3:0];
                    CFG_BACKOFF_MIN: bo_min_reg    <= cfg_data[7:0];
                    CFG_BACKOFF_MAX: bo_max_reg    <= cfg_data[7:0];
                    default:         ack_to_reg    <= ack_to_reg;
                endcase
            end
            if (go)
            begin
                stage_reg     <= stage_next;
                waiting_reg   <= waiting_next;
                listening_reg <= listening_next;
                retries_reg   <= retries_next;
                ack_el_reg    <= ack_el_next;
                csma_el_reg   <= csma_el_next;
                scan_pend_reg <= scan_pend_next;
                held_reg      <= held_next;
                div_cnt_reg   <= '0;
                res_valid_reg <= !start_div;
            end
            else if (div_done)
            begin
                backoff_reg   <= backoff_next;
                res_valid_reg <= 1'b1;
            end
            else
            begin
                if (bstate_reg == BK_DIV)
                begin
                    div_cnt_reg <= div_cnt_reg + 1'b1;
                end
                if (pop)
                begin
                    res_valid_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (go)
        begin
            act_reg     <= act;
            mlen_reg    <= mlen;
            retry_reg   <= retries_next;
            await_reg   <= waiting_next;
            div_num_reg <= lfsr_step;
            div_rem_reg <= '0;
        end
        else if (bstate_reg == BK_DIV)
        begin
            div_num_reg <= div_num_next;
            div_rem_reg <= div_rem_next;
        end
    end

    assign empty          = !res_valid_reg;
    assign action         = act_reg;
    assign message_length = mlen_reg;
    assign retry_count    = retry_reg;
    assign awaiting_ack   = await_reg;

    `SMAC_ASSERT_NOW(a_no_pop_while_div, bstate_reg == BK_DIV, !q_pop && !res_valid_reg)
    `SMAC_ASSERT_NOW(a_lfsr_nonzero, 1'b1, lfsr_reg != '0)
    `SMAC_ASSERT_NOW(a_scan_only_sending, scan_pend_reg, stage_reg != STG_IDLE)
    `SMAC_ASSERT_NEXT(a_div_ends_valid, div_done, res_valid_reg && bstate_reg == BK_RUN)

endmodule

@@ rtl/stop_and_wait_arq_csma_mac.sv @@
// Top level of the stop-and-wait link controller with listen-before-talk.
// A result is registered when the back end takes its event from the queue; a busy scan
// that draws a new backoff first runs the serial remainder unit (four bits per cycle).
// Throughput: one event per cycle while results are popped; none during a backoff draw.
// Reset: asynchronous, active low; state registers return to defaults, no clearing pass.
module stop_and_wait_arq_csma_mac #(
    parameter int MAX_PAYLOAD = 64,
    parameter int TIMER_BITS  = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    // Event input queue side.
    input  logic        push,
    output logic        full,
    input  logic [1:0]  req_type,
    input  logic [1:0]  rx_kind,
    input  logic [1:0]  scan_status,
    input  logic [6:0]  host_length,
    // Result queue side.
    output logic        empty,
    input  logic        pop,
    output logic [2:0]  action,
    output logic [6:0]  message_length,
    output logic [3:0]  retry_count,
    output logic        awaiting_ack,
    // Configuration write channel.
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data
);
    import smac_pkg::*;

    // The front end classifies each event transfer and parks it in a short queue, so that
    // new events are still taken while the back end draws a backoff or while a finished
    // result waits to be popped.
    item_t q_item;
    logic  q_empty;
    logic  q_pop;

    smac_front #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .req_type    (req_type),
        .rx_kind     (rx_kind),
        .scan_status (scan_status),
        .host_length (host_length),
        .q_pop       (q_pop),
        .q_item      (q_item),
        .q_empty     (q_empty)
    );

    // The back end owns the sender and acker state, the timers and the random
    // generator. Each queued event yields exactly one result transfer.
    smac_back #(
        .TIMER_BITS (TIMER_BITS)
    ) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .q_item         (q_item),
        .q_empty        (q_empty),
        .q_pop          (q_pop),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .empty          (empty),
        .pop            (pop),
        .action         (action),
        .message_length (message_length),
        .retry_count    (retry_count),
        .awaiting_ack   (awaiting_ack)
    );

endmodule

@@ dv/tb.sv @@
// Self-checking testbench for the stop-and-wait link controller with listen-before-talk.
`timescale 1ns / 100ps

module tb;
    import smac_pkg::*;

    // Input codes that the package leaves unnamed.
    localparam logic [1:0] REQ_SCAN = 2'd3;
    localparam logic [1:0] RX_OTHER = 2'd2;
    localparam logic [1:0] SCAN_ERR = 2'd2;

    localparam int          PAYLOAD_MAX = 64;
    localparam int          TMR_BITS    = 16;
    localparam logic [15:0] TMR_MAX     = 16'hFFFF;

    // One result of the controller, in the order of its ports.
    typedef struct packed {
        act_t       act;
        logic [6:0] len;
        logic [3:0] retries;
        logic       awaiting;
    } link_result_t;

    localparam link_result_t NO_RESULT = '{ACT_NONE, 7'd0, 4'd0, 1'b0};

    // One row of the directed table; reps repeats the event, and typed marks rows
    // whose result is written out by hand instead of taken from the predictor.
    typedef struct packed {
        logic [1:0]   req;
        logic [1:0]   rx;
        logic [1:0]   scan;
        logic [6:0]   hlen;
        logic [6:0]   reps;
        logic         typed;
        link_result_t res;
    } dir_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        push = 1'b0;
    logic        full;
    logic [1:0]  req_type = 2'd0;
    logic [1:0]  rx_kind = 2'd0;
    logic [1:0]  scan_status = 2'd0;
    logic [6:0]  host_length = 7'd0;
    logic        empty;
    logic        pop = 1'b0;
    logic [2:0]  action;
    logic [6:0]  message_length;
    logic [3:0]  retry_count;
    logic        awaiting_ack;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = 3'd0;
    logic [31:0] cfg_data = 32'd0;

    stop_and_wait_arq_csma_mac #(
        .MAX_PAYLOAD(PAYLOAD_MAX),
        .TIMER_BITS (TMR_BITS)
    ) u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .full          (full),
        .req_type      (req_type),
        .rx_kind       (rx_kind),
        .scan_status   (scan_status),
        .host_length   (host_length),
        .empty         (empty),
        .pop           (pop),
        .action        (action),
        .message_length(message_length),
        .retry_count   (retry_count),
        .awaiting_ack  (awaiting_ack),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Register copies held by the predictor.
    logic [15:0] cf_timeout;
    logic [3:0]  cf_retry;
    logic [7:0]  cf_bmin;
    logic [7:0]  cf_bmax;
    logic [31:0] cf_seed;

    // Link state held by the predictor.
    stage_t      pr_stage;
    logic        pr_wait;
    logic        pr_listen;
    logic        pr_scan_pend;
    logic [3:0]  pr_retries;
    logic [15:0] pr_ack_t;
    logic [15:0] pr_csma_t;
    logic [7:0]  pr_backoff;
    logic [6:0]  pr_held;
    logic [31:0] pr_lfsr;

    // Results still owed by the block, oldest first.
    link_result_t pending_actions[$];
    int           fails = 0;

    // Set by the sender to hold pop high during the steady run.
    logic         rx_steady = 1'b0;
    logic         rx_on = 1'b0;
    int           rx_left = 0;

    dir_row_t     dir_rows [22];

    // A scan may be requested only when none is outstanding and the backoff
    // has fully elapsed since the last free or busy scan outcome.
    function automatic act_t request_scan();
        if (!pr_scan_pend && pr_csma_t >= {8'd0, pr_backoff})
        begin
            pr_scan_pend = 1'b1;
            return ACT_REQ_SCAN;
        end
        return ACT_NONE;
    endfunction

    // The receiver is started once per idle period; a transmit clears the flag.
    function automatic act_t listen_if_needed();
        if (!pr_listen)
        begin
            pr_listen = 1'b1;
            return ACT_START_RX;
        end
        return ACT_NONE;
    endfunction

    // Advances the predicted link state by one event and returns the action it
    // produces. no_effect is set for events that the block simply drops.
    task automatic step_link_model(input logic [1:0] req, input logic [1:0] rx,
                                   input logic [1:0] scan, input logic [6:0] hlen,
                                   output link_result_t res, output bit no_effect);
        act_t        act;
        logic [6:0]  mlen;
        int unsigned lo;
        int unsigned hi;
        int unsigned tmp;
        act = ACT_NONE;
        mlen = 7'd0;
        no_effect = 1'b0;
        case (req)
            REQ_TICK:
            begin
                // Both timers saturate rather than wrap.
                if (pr_ack_t != TMR_MAX) pr_ack_t = pr_ack_t + 16'd1;
                if (pr_csma_t != TMR_MAX) pr_csma_t = pr_csma_t + 16'd1;
                if (pr_stage == STG_IDLE)
                begin
                    if (pr_wait && (pr_ack_t > cf_timeout || pr_ack_t == TMR_MAX))
                    begin
                        if (pr_retries < cf_retry)
                        begin
                            pr_retries = pr_retries + 4'd1;
                            pr_stage = STG_SEND_MSG;
                            act = request_scan();
                        end
                        else
                        begin
                            pr_wait = 1'b0;
                            pr_retries = 4'd0;
                            act = ACT_GAVE_UP;
                        end
                    end
                    else
                    begin
                        act = listen_if_needed();
                    end
                end
                else
                begin
                    act = request_scan();
                end
            end
            REQ_HOST:
            begin
                if (pr_stage == STG_IDLE && !pr_wait)
                begin
                    pr_held = (hlen > PAYLOAD_MAX) ? 7'(PAYLOAD_MAX) : hlen;
                    if (pr_held != 7'd0)
                    begin
                        pr_stage = STG_SEND_MSG;
                        act = request_scan();
                    end
                    else
                    begin
                        act = listen_if_needed();
                    end
                end
                else
                begin
                    no_effect = 1'b1;
                end
            end
            REQ_RX:
            begin
                if (pr_stage == STG_IDLE && rx == RX_MSG)
                begin
                    pr_stage = STG_SEND_ACK;
                    act = ACT_DELIVER;
                end
                else if (pr_stage == STG_IDLE && rx == RX_ACK)
                begin
                    pr_wait = 1'b0;
                    pr_retries = 4'd0;
                    pr_ack_t = 16'd0;
                end
                else
                begin
                    no_effect = 1'b1;
                end
            end
            default:
            begin
                if (pr_scan_pend && pr_stage != STG_IDLE)
                begin
                    pr_scan_pend = 1'b0;
                    if (scan == SCAN_FREE)
                    begin
                        pr_csma_t = 16'd0;
                        pr_listen = 1'b0;
                        if (pr_stage == STG_SEND_MSG)
                        begin
                            act = ACT_SEND_MSG;
                            mlen = pr_held;
                            pr_wait = 1'b1;
                            pr_ack_t = 16'd0;
                        end
                        else
                        begin
                            act = ACT_SEND_ACK;
                        end
                        pr_stage = STG_IDLE;
                    end
                    else if (scan == SCAN_BUSY)
                    begin
                        // New backoff: min plus the next LFSR value modulo the span,
                        // with min and max swapped when given the wrong way round.
                        pr_csma_t = 16'd0;
                        lo = cf_bmin;
                        hi = cf_bmax;
                        if (lo > hi)
                        begin
                            tmp = lo;
                            lo = hi;
                            hi = tmp;
                        end
                        pr_lfsr = pr_lfsr[0] ? ((pr_lfsr >> 1) ^ LFSR_TAPS) : (pr_lfsr >> 1);
                        if (pr_lfsr == 32'd0) pr_lfsr = 32'd1;
                        pr_backoff = 8'(lo + (pr_lfsr % (hi - lo + 1)));
                    end
                end
                else
                begin
                    no_effect = 1'b1;
                end
            end
        endcase
        res = '{act, mlen, pr_retries, pr_wait};
    endtask

    // Presents one event and holds it until the queue takes the transfer. The
    // expected result is recorded at the edge of acceptance, so the store stays in
    // the order in which the block sees its events.
    task automatic send_event(input logic [1:0] req, input logic [1:0] rx,
                              input logic [1:0] scan, input logic [6:0] hlen,
                              input bit typed, input link_result_t typed_res,
                              output bit no_effect);
        link_result_t res;
        push <= 1'b1;
        req_type <= req;
        rx_kind <= rx;
        scan_status <= scan;
        host_length <= hlen;
        do @(posedge clk); while (full);
        step_link_model(req, rx, scan, hlen, res, no_effect);
        pending_actions.push_back(typed ? typed_res : res);
    endtask

    // Waits until every owed result has been popped, then lets the block settle
    // for longer than its slowest event (a backoff draw) could take.
    task automatic settle_link();
        push <= 1'b0;
        while (pending_actions.size() != 0) @(posedge clk);
        repeat (16) @(posedge clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            CFG_ACK_TIMEOUT: cf_timeout = data[15:0];
            CFG_RETRY_LIMIT: cf_retry = data[3:0];
            CFG_BACKOFF_MIN: cf_bmin = data[7:0];
            CFG_BACKOFF_MAX: cf_bmax = data[7:0];
            CFG_RNG_SEED:
            begin
                // A seed write also reloads the generator; zero is loaded as one.
                cf_seed = data;
                pr_lfsr = (data == 32'd0) ? 32'd1 : data;
            end
            default: ;
        endcase
    endtask

    // Writes the full register set while the block is idle.
    task automatic configure_link(input logic [15:0] timeout, input logic [3:0] retry,
                                  input logic [7:0] bmin, input logic [7:0] bmax,
                                  input logic [31:0] seed);
        settle_link();
        write_reg(CFG_ACK_TIMEOUT, {16'd0, timeout});
        write_reg(CFG_RETRY_LIMIT, {28'd0, retry});
        write_reg(CFG_BACKOFF_MIN, {24'd0, bmin});
        write_reg(CFG_BACKOFF_MAX, {24'd0, bmax});
        write_reg(CFG_RNG_SEED, seed);
        cfg_valid <= 1'b0;
    endtask

    // Random traffic until quota events have taken effect. Most events follow what
    // the link is waiting for next, so that sends, retries and give-ups are reached;
    // the rest are noise. In flood mode the sender and receiver never idle and the
    // traffic is a plain send followed by ticks.
    task automatic run_phase(input int quota, input bit flood);
        int          done;
        int          burst_left;
        int          gap;
        int unsigned pick;
        int unsigned pick_len;
        int unsigned pick_scan;
        bit          noise;
        bit          no_effect;
        logic [1:0]  req;
        logic [1:0]  rx;
        logic [1:0]  scan;
        logic [6:0]  hlen;
        done = 0;
        burst_left = $urandom_range(1, 20);
        rx_steady <= flood;
        while (done < quota)
        begin
            req = 2'($urandom_range(0, 3));
            rx = 2'($urandom_range(0, 3));
            scan = 2'($urandom_range(0, 3));
            hlen = 7'($urandom_range(0, 127));
            noise = ($urandom_range(0, 11) == 0);
            pick = $urandom_range(0, 99);
            if (flood)
            begin
                if (pr_stage != STG_IDLE && pr_scan_pend)
                begin
                    req = REQ_SCAN;
                    scan = SCAN_FREE;
                end
                else if (pr_stage == STG_IDLE && !pr_wait)
                begin
                    req = REQ_HOST;
                    hlen = 7'd10;
                end
                else
                begin
                    req = REQ_TICK;
                end
            end
            else if (!noise)
            begin
                if (pr_stage != STG_IDLE && pr_scan_pend)
                begin
                    req = (pick < 60) ? REQ_SCAN : REQ_TICK;
                    pick_scan = $urandom_range(0, 19);
                    if (pick_scan < 10) scan = SCAN_FREE;
                    else if (pick_scan < 16) scan = SCAN_BUSY;
                    else scan = 2'($urandom_range(SCAN_ERR, 3));
                end
                else if (pr_stage != STG_IDLE)
                begin
                    if (pick < 85) req = REQ_TICK;
                end
                else if (!pr_wait)
                begin
                    if (pick < 30) req = REQ_HOST;
                    else if (pick < 45) req = REQ_RX;
                    else req = REQ_TICK;
                end
                else
                begin
                    if (pick < 10)
                    begin
                        req = REQ_RX;
                        rx = RX_ACK;
                    end
                    else if (pick < 14)
                    begin
                        req = REQ_RX;
                        rx = RX_MSG;
                    end
                    else if (pick >= 17)
                    begin
                        req = REQ_TICK;
                    end
                    else
                    begin
                        req = REQ_HOST;
                    end
                end
                // Host lengths lean toward the clamp boundary and to zero.
                pick_len = $urandom_range(0, 19);
                if (pick_len < 2) hlen = 7'd0;
                else if (pick_len < 4) hlen = 7'($urandom_range(PAYLOAD_MAX + 1, 127));
                else if (pick_len == 4) hlen = 7'(PAYLOAD_MAX);
                else hlen = 7'($urandom_range(1, PAYLOAD_MAX - 1));
            end
            send_event(req, rx, scan, hlen, 1'b0, NO_RESULT, no_effect);
            if (!no_effect) done++;
            if (!flood)
            begin
                if (burst_left == 0)
                begin
                    burst_left = $urandom_range(1, 20);
                    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                    if (gap != 0)
                    begin
                        push <= 1'b0;
                        repeat (gap) @(posedge clk);
                    end
                end
                else
                begin
                    burst_left--;
                end
            end
        end
        rx_steady <= 1'b0;
    endtask

    // Receiver: alternating runs of pop high and pop low, of random lengths, with
    // an occasional long run without stalls.
    always @(posedge clk)
    begin
        if (rx_steady)
        begin
            pop <= 1'b1;
        end
        else
        begin
            if (rx_left == 0)
            begin
                rx_on = !rx_on;
                if (!rx_on) rx_left = $urandom_range(1, 6);
                else if ($urandom_range(0, 3) == 0) rx_left = $urandom_range(30, 80);
                else rx_left = $urandom_range(1, 12);
            end
            else
            begin
                rx_left--;
            end
            pop <= rx_on;
        end
    end

    // Every popped transfer is compared with the oldest owed result.
    always @(posedge clk)
    begin
        link_result_t exp_res;
        if (rst_n && pop && !empty)
        begin
            if (pending_actions.size() == 0)
            begin
                $error("result with no event owed: action %0d length %0d", action,
                       message_length);
                fails++;
            end
            else
            begin
                exp_res = pending_actions.pop_front();
                if (action !== exp_res.act)
                begin
                    $error("action: expected %0d, actual %0d", exp_res.act, action);
                    fails++;
                end
                if (message_length !== exp_res.len)
                begin
                    $error("message_length: expected %0d, actual %0d", exp_res.len,
                           message_length);
                    fails++;
                end
                if (retry_count !== exp_res.retries)
                begin
                    $error("retry_count: expected %0d, actual %0d", exp_res.retries,
                           retry_count);
                    fails++;
                end
                if (awaiting_ack !== exp_res.awaiting)
                begin
                    $error("awaiting_ack: expected %0d, actual %0d", exp_res.awaiting,
                           awaiting_ack);
                    fails++;
                end
            end
        end
    end

    initial
    begin
        bit no_effect;
        int cfg_round;

        // Directed events from reset defaults: timeout 50, two retries, backoff 2 to 10,
        // seed 1, so the first busy scan draws a backoff of six ticks.
        dir_rows = '{
            '{REQ_TICK, RX_MSG,   SCAN_FREE, 7'd0,   7'd1, 1'b1,
              '{ACT_START_RX, 7'd0, 4'd0, 1'b0}},
            '{REQ_TICK, RX_MSG,   SCAN_FREE, 7'd0,   7'd1, 1'b1, NO_RESULT},
            // A scan outcome with no scan outstanding is dropped.
            '{REQ_SCAN, RX_MSG,   SCAN_FREE, 7'd0,   7'd1, 1'b1, NO_RESULT},
            '{REQ_RX,   RX_ACK,   SCAN_FREE, 7'd0,   7'd1, 1'b1, NO_RESULT},
            '{REQ_RX,   RX_OTHER, SCAN_FREE, 7'd0,   7'd1, 1'b1, NO_RESULT},
            '{REQ_RX,   2'd3,     SCAN_FREE, 7'd0,   7'd1, 1'b1, NO_RESULT},
            // Zero host length: nothing to send, and the receiver already runs.
            '{REQ_HOST, RX_MSG,   SCAN_FREE, 7'd0,   7'd1, 1'b1, NO_RESULT},
            // The longest host length is clamped to the payload limit.
            '{REQ_HOST, RX_MSG,   SCAN_FREE, 7'd127, 7'd1, 1'b1,
              '{ACT_REQ_SCAN, 7'd0, 4'd0, 1'b0}},
            // Packets and host data are dropped while a send is under way.
            '{REQ_RX,   RX_MSG,   SCAN_FREE, 7'd0,   7'd1, 1'b1, NO_RESULT},
            '{REQ_HOST, RX_MSG,   SCAN_FREE, 7'd5,   7'd1, 1'b1, NO_RESULT},
            '{REQ_SCAN, RX_MSG,   SCAN_BUSY, 7'd0,   7'd1, 1'b0, NO_RESULT},
            '{REQ_TICK, RX_MSG,   SCAN_FREE, 7'd0,   7'd6, 1'b0, NO_RESULT},
            // Scan errors in both encodings; the scan is requested again on a tick.
            '{REQ_SCAN, RX_MSG,   SCAN_ERR,  7'd0,   7'd1, 1'b0, NO_RESULT},
            '{REQ_TICK, RX_MSG,   SCAN_FREE, 7'd0,   7'd1, 1'b0, NO_RESULT},
            '{REQ_SCAN, RX_MSG,   2'd3,      7'd0,   7'd1, 1'b0, NO_RESULT},
            '{REQ_TICK, RX_MSG,   SCAN_FREE, 7'd0,   7'd1, 1'b0, NO_RESULT},
            '{REQ_SCAN, RX_MSG,   SCAN_FREE, 7'd0,   7'd1, 1'b1,
              '{ACT_SEND_MSG, 7'd64, 4'd0, 1'b1}},
            // Host data is dropped while an ACK is owed.
            '{REQ_HOST, RX_MSG,   SCAN_FREE, 7'd20,  7'd1, 1'b1,
              '{ACT_NONE, 7'd0, 4'd0, 1'b1}},
            '{REQ_RX,   RX_ACK,   SCAN_FREE, 7'd0,   7'd1, 1'b1, NO_RESULT},
            '{REQ_RX,   RX_MSG,   SCAN_FREE, 7'd0,   7'd1, 1'b1,
              '{ACT_DELIVER, 7'd0, 4'd0, 1'b0}},
            '{REQ_TICK, RX_MSG,   SCAN_FREE, 7'd0,   7'd6, 1'b0, NO_RESULT},
            '{REQ_SCAN, RX_MSG,   SCAN_FREE, 7'd0,   7'd1, 1'b1,
              '{ACT_SEND_ACK, 7'd0, 4'd0, 1'b0}}
        };

        cf_timeout = ACK_TIMEOUT_RST;
        cf_retry = RETRY_LIMIT_RST;
        cf_bmin = BACKOFF_MIN_RST;
        cf_bmax = BACKOFF_MAX_RST;
        cf_seed = RNG_SEED_RST;
        pr_stage = STG_IDLE;
        pr_wait = 1'b0;
        pr_listen = 1'b0;
        pr_scan_pend = 1'b0;
        pr_retries = 4'd0;
        pr_ack_t = 16'd0;
        pr_csma_t = 16'd0;
        pr_backoff = 8'd0;
        pr_held = 7'd0;
        pr_lfsr = RNG_SEED_RST;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
        begin
            repeat (dir_rows[i].reps)
            begin
                send_event(dir_rows[i].req, dir_rows[i].rx, dir_rows[i].scan,
                           dir_rows[i].hlen, dir_rows[i].typed, dir_rows[i].res,
                           no_effect);
            end
        end

        // Low extremes: immediate ACK expiry, no retries, a fixed zero backoff and
        // a zero seed.
        configure_link(16'd0, 4'd0, 8'd0, 8'd0, 32'd0);
        run_phase(180, 1'b0);

        // High extremes with min above max, so the span covers all 256 values.
        configure_link(16'd2, 4'd15, 8'd255, 8'd0, 32'hFFFF_FFFF);
        run_phase(180, 1'b0);

        configure_link(16'd1, 4'd15, 8'd7, 8'd7, $urandom);
        run_phase(180, 1'b0);

        for (cfg_round = 0; cfg_round < 5; cfg_round++)
        begin
            configure_link(($urandom_range(0, 7) == 0) ? 16'($urandom_range(0, 65535))
                                                      : 16'($urandom_range(0, 60)),
                           4'($urandom_range(0, 15)),
                           ($urandom_range(0, 5) == 0) ? 8'($urandom_range(0, 255))
                                                      : 8'($urandom_range(0, 16)),
                           ($urandom_range(0, 5) == 0) ? 8'($urandom_range(0, 255))
                                                      : 8'($urandom_range(0, 16)),
                           $urandom);
            run_phase(180, 1'b0);
        end

        // With the largest timeout a send is followed by a plain run of ticks while
        // the sender and receiver never stall.
        configure_link(16'hFFFF, 4'd1, 8'd0, 8'd3, $urandom);
        run_phase(100, 1'b1);

        configure_link(ACK_TIMEOUT_RST, RETRY_LIMIT_RST, BACKOFF_MIN_RST, BACKOFF_MAX_RST,
                       RNG_SEED_RST);
        run_phase(180, 1'b0);

        settle_link();
        if (fails == 0)
        begin
            $display("*** PASSED ***");
        end
        else
        begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    // Watchdog against a hung handshake.
    initial
    begin
        #12_000_000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule
